// ----- design/psf_pkg.sv -----
// Package for the packet source filter with flow statistics.
// Holds the classifier constants, register indexes, flow entry type and state type.
// Used by the filter, its flow memory and the bench; depends on nothing.
package psf_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ALLOWED_IP_0 = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ALLOWED_IP_1 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALLOWED_IP_2 = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ALLOWED_IP_3 = 2'd3;

  localparam logic [31:0] ALLOWED_IP_0_RESET = 32'h0808_0808;
  localparam logic [31:0] ALLOWED_IP_1_RESET = 32'h0808_0404;
  localparam logic [31:0] ALLOWED_IP_2_RESET = 32'h0101_0101;
  localparam logic [31:0] ALLOWED_IP_3_RESET = 32'h0100_0001;

  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [15:0] MIN_LEN_UDP = 16'd28;
  localparam logic [15:0] MIN_LEN_TCP = 16'd40;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [15:0] PORT_ALT = 16'd8080;
  localparam logic [15:0] PORT_ALT_HTTPS = 16'd8443;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] count;
    logic [47:0] lat_sum;
  } flow_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_MUL,
    ST_ADD,
    ST_SEARCH,
    ST_UPDATE,
    ST_EMIT
  } state_t;

endpackage

// ----- design/psf_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// The dividend's upper half must be below the divisor so the quotient fits 32 bits.
// Depends on nothing but its ports.
module psf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] lo;
  logic [4:0]  cnt;
  logic [32:0] shifted;
  logic        fits;

  assign shifted  = {rem, lo[31]};
  assign fits     = shifted >= {1'b0, divisor};
  assign quotient = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '1;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[63:32];
      lo  <= dividend[31:0];
    end else if (busy) begin
      rem <= fits ? 32'(shifted - {1'b0, divisor}) : shifted[31:0];
      lo  <= {lo[30:0], fits};
    end
  end

endmodule

// ----- design/psf_flow_mem.sv -----
// Learned flow table: entry memory with registered read and one write port,
// plus valid bits in flops that reset clears. Depends on psf_pkg.
module psf_flow_mem #(
  parameter int unsigned FLOW_DEPTH = psf_pkg::DEPTH_DEFAULT,
  localparam int unsigned IW = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IW-1:0]        rd_addr,
  output psf_pkg::flow_entry_t rd_data,
  output logic                 rd_valid,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_addr,
  input  psf_pkg::flow_entry_t wr_data
);

  psf_pkg::flow_entry_t entries [FLOW_DEPTH];
  logic [FLOW_DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
    rd_data <= entries[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

// ----- design/packet_source_filter_flow_stats.sv -----
// Packet source filter with flow statistics: classifies each packet and keeps counters,
// latency min, max and running mean, and a learned flow table scanned one entry a cycle.
// A rejected packet goes from classification straight to emit; a matched one runs multiply,
// add, a table search with the divider for the mean started alongside, and an update that
// waits for the divider to finish, then emits. One packet at a time: the next is taken only
// once the block is back in idle; done pulses and the receiver cannot stall.
// Synchronous reset clears all counters, valid bits and the allowed addresses to defaults.
module packet_source_filter_flow_stats #(
  parameter int unsigned FLOW_DEPTH = psf_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   src_ip,
  input  logic [7:0]                    protocol,
  input  logic [15:0]                   packet_length,
  input  logic [15:0]                   src_port,
  input  logic [31:0]                   latency,
  input  logic                          wr_en,
  input  logic [psf_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [31:0]                   wr_data,
  output logic                          done,
  output logic                          is_market,
  output logic [3:0]                    flow_slot,
  output logic                          flow_new,
  output logic                          table_full,
  output logic [31:0]                   flow_packets,
  output logic [47:0]                   flow_latency_total,
  output logic [31:0]                   market_total,
  output logic [31:0]                   filtered_total,
  output logic [31:0]                   latency_min,
  output logic [31:0]                   latency_max,
  output logic [31:0]                   latency_avg,
  output logic [4:0]                    active_flows
);

  localparam int unsigned IW = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FLOW_DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(FLOW_DEPTH - 1);

  psf_pkg::state_t state, state_next;

  logic [31:0] allowed_ip_0, allowed_ip_1, allowed_ip_2, allowed_ip_3;
  logic [31:0] in_ip, in_lat;
  logic [7:0]  in_proto;
  logic [15:0] in_len, in_port;

  logic [31:0] market_count, reject_count, min_lat, max_lat, mean_lat;
  logic [CW-1:0] flow_total;
  logic [63:0] prod, acc;
  logic        div_used, div_start, div_busy;
  logic [31:0] div_q;

  logic [IW-1:0] scan, cmp_idx, hit_idx, free_idx;
  logic          scan_done, cmp_en, hit_found, free_found;
  logic [31:0]   hit_count;
  logic [47:0]   hit_sum;

  psf_pkg::flow_entry_t rd_data, wr_entry;
  logic                 rd_valid, mem_we;
  logic [IW-1:0]        wr_slot;

  logic [IW-1:0] slot_reg;
  logic [IW+3:0] slot_wide;
  logic [CW+4:0] total_wide;

  logic ip_ok, len_ok, port_ok, match, update_go;

  assign ip_ok = (in_ip == allowed_ip_0) || (in_ip == allowed_ip_1) ||
                 (in_ip == allowed_ip_2) || (in_ip == allowed_ip_3);
  assign len_ok = ((in_proto == psf_pkg::PROTO_UDP) && (in_len >= psf_pkg::MIN_LEN_UDP)) ||
                  ((in_proto == psf_pkg::PROTO_TCP) && (in_len >= psf_pkg::MIN_LEN_TCP));
  assign port_ok = (in_port == psf_pkg::PORT_HTTPS) || (in_port == psf_pkg::PORT_ALT) ||
                   (in_port == psf_pkg::PORT_ALT_HTTPS);
  assign match = ip_ok && len_ok && port_ok;

  assign update_go = (state == psf_pkg::ST_UPDATE) && !div_busy;
  assign wr_slot   = hit_found ? hit_idx : free_idx;
  assign mem_we    = update_go && (hit_found || free_found);

  always_comb begin
    wr_entry.addr = in_ip;
    wr_entry.port = in_port;
    if (hit_found) begin
      wr_entry.count   = hit_count + 32'd1;
      wr_entry.lat_sum = hit_sum + {16'd0, in_lat};
    end else begin
      wr_entry.count   = 32'd1;
      wr_entry.lat_sum = {16'd0, in_lat};
    end
  end

  psf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (market_count),
    .busy     (div_busy),
    .quotient (div_q)
  );

  psf_flow_mem #(
    .FLOW_DEPTH (FLOW_DEPTH)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (scan),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .wr_en    (mem_we),
    .wr_addr  (wr_slot),
    .wr_data  (wr_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      psf_pkg::ST_IDLE: begin
        if (start) begin
          state_next = psf_pkg::ST_CLASS;
        end
      end
      psf_pkg::ST_CLASS: begin
        state_next = match ? psf_pkg::ST_MUL : psf_pkg::ST_EMIT;
      end
      psf_pkg::ST_MUL: begin
        state_next = psf_pkg::ST_ADD;
      end
      psf_pkg::ST_ADD: begin
        state_next = psf_pkg::ST_SEARCH;
      end
      psf_pkg::ST_SEARCH: begin
        div_start = (scan == '0) && !scan_done && !cmp_en && div_used;
        if (cmp_en && (cmp_idx == LAST)) begin
          state_next = psf_pkg::ST_UPDATE;
        end
      end
      psf_pkg::ST_UPDATE: begin
        if (!div_busy) begin
          state_next = psf_pkg::ST_EMIT;
        end
      end
      psf_pkg::ST_EMIT: begin
        state_next = psf_pkg::ST_IDLE;
      end
      default: begin
        state_next = psf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_ip_0 <= psf_pkg::ALLOWED_IP_0_RESET;
      allowed_ip_1 <= psf_pkg::ALLOWED_IP_1_RESET;
      allowed_ip_2 <= psf_pkg::ALLOWED_IP_2_RESET;
      allowed_ip_3 <= psf_pkg::ALLOWED_IP_3_RESET;
    end else if (wr_en) begin
      case (wr_index)
        psf_pkg::REG_ALLOWED_IP_0: allowed_ip_0 <= wr_data;
        psf_pkg::REG_ALLOWED_IP_1: allowed_ip_1 <= wr_data;
        psf_pkg::REG_ALLOWED_IP_2: allowed_ip_2 <= wr_data;
        psf_pkg::REG_ALLOWED_IP_3: allowed_ip_3 <= wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      market_count <= '0;
      reject_count <= '0;
      min_lat      <= '0;
      max_lat      <= '0;
      mean_lat     <= '0;
      flow_total   <= '0;
      scan_done    <= 1'b0;
      cmp_en       <= 1'b0;
      hit_found    <= 1'b0;
      free_found   <= 1'b0;
      div_used     <= 1'b0;
    end else begin
      case (state)
        psf_pkg::ST_CLASS: begin
          scan       <= '0;
          scan_done  <= 1'b0;
          cmp_en     <= 1'b0;
          hit_found  <= 1'b0;
          free_found <= 1'b0;
          if (match) begin
            market_count <= market_count + 32'd1;
            if ((min_lat == '0) || (in_lat < min_lat)) begin
              min_lat <= in_lat;
            end
            if (in_lat > max_lat) begin
              max_lat <= in_lat;
            end
          end else begin
            reject_count <= reject_count + 32'd1;
          end
        end
        psf_pkg::ST_ADD: begin
          div_used <= market_count != '0;
        end
        psf_pkg::ST_SEARCH: begin
          cmp_en  <= !scan_done;
          cmp_idx <= scan;
          if (!scan_done) begin
            if (scan == LAST) begin
              scan_done <= 1'b1;
            end else begin
              scan <= scan + IW'(1);
            end
          end
          if (cmp_en) begin
            if (rd_valid && !hit_found && (rd_data.addr == in_ip) &&
                (rd_data.port == in_port)) begin
              hit_found <= 1'b1;
              hit_idx   <= cmp_idx;
              hit_count <= rd_data.count;
              hit_sum   <= rd_data.lat_sum;
            end
            if (!rd_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
          end
        end
        psf_pkg::ST_UPDATE: begin
          cmp_en <= 1'b0;
          if (!div_busy) begin
            if (div_used) begin
              mean_lat <= div_q;
            end
            if (!hit_found && free_found) begin
              flow_total <= flow_total + CW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == psf_pkg::ST_IDLE) && start) begin
      in_ip    <= src_ip;
      in_proto <= protocol;
      in_len   <= packet_length;
      in_port  <= src_port;
      in_lat   <= latency;
    end
    if (state == psf_pkg::ST_MUL) begin
      prod <= mean_lat * (market_count - 32'd1);
    end
    if (state == psf_pkg::ST_ADD) begin
      acc <= prod + {32'd0, in_lat};
    end
    if (state == psf_pkg::ST_CLASS) begin
      is_market          <= match;
      slot_reg           <= '0;
      flow_new           <= 1'b0;
      table_full         <= 1'b0;
      flow_packets       <= '0;
      flow_latency_total <= '0;
    end
    if (update_go) begin
      if (hit_found || free_found) begin
        slot_reg           <= wr_slot;
        flow_new           <= !hit_found;
        flow_packets       <= wr_entry.count;
        flow_latency_total <= wr_entry.lat_sum;
      end else begin
        table_full <= 1'b1;
      end
    end
  end

  assign slot_wide  = {4'd0, slot_reg};
  assign total_wide = {5'd0, flow_total};

  assign busy           = state != psf_pkg::ST_IDLE;
  assign done           = state == psf_pkg::ST_EMIT;
  assign flow_slot      = slot_wide[3:0];
  assign active_flows   = total_wide[4:0];
  assign market_total   = market_count;
  assign filtered_total = reject_count;
  assign latency_min    = min_lat;
  assign latency_max    = max_lat;
  assign latency_avg    = mean_lat;

endmodule

// ----- bench/psf_flow_stats_checker.sv -----
// Checker for the packet source filter: watches the command, register and result ports,
// predicts every result word and compares it field by field with what the block emits.
// Depends on psf_pkg for the classifier constants and register indexes.
module psf_flow_stats_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [31:0]                   src_ip,
  input  logic [7:0]                    protocol,
  input  logic [15:0]                   packet_length,
  input  logic [15:0]                   src_port,
  input  logic [31:0]                   latency,
  input  logic                          wr_en,
  input  logic [psf_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [31:0]                   wr_data,
  input  logic                          done,
  input  logic                          is_market,
  input  logic [3:0]                    flow_slot,
  input  logic                          flow_new,
  input  logic                          table_full,
  input  logic [31:0]                   flow_packets,
  input  logic [47:0]                   flow_latency_total,
  input  logic [31:0]                   market_total,
  input  logic [31:0]                   filtered_total,
  input  logic [31:0]                   latency_min,
  input  logic [31:0]                   latency_max,
  input  logic [31:0]                   latency_avg,
  input  logic [4:0]                    active_flows,
  output int                            fail_count,
  output int                            pending,
  output int                            matched_seen,
  output int                            full_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = int'(psf_pkg::DEPTH_DEFAULT);

  typedef struct packed {
    logic        market;
    logic [3:0]  slot;
    logic        fresh;
    logic        full;
    logic [31:0] packets;
    logic [47:0] lat_total;
    logic [31:0] market_cnt;
    logic [31:0] reject_cnt;
    logic [31:0] lat_min;
    logic [31:0] lat_max;
    logic [31:0] lat_avg;
    logic [4:0]  flows;
  } stats_word_t;

  stats_word_t expected_words[$];

  logic [31:0] allowed_addr[4];
  logic        entry_valid[TABLE_DEPTH];
  logic [31:0] entry_addr[TABLE_DEPTH];
  logic [15:0] entry_port[TABLE_DEPTH];
  logic [31:0] entry_count[TABLE_DEPTH];
  logic [47:0] entry_sum[TABLE_DEPTH];
  logic [31:0] n_market, n_reject, min_seen, max_seen, mean_seen;
  logic [4:0]  n_flows;

  function automatic logic passes_filter(logic [31:0] ip, logic [7:0] proto,
                                         logic [15:0] len, logic [15:0] port);
    logic ip_ok, len_ok;
    ip_ok = (ip == allowed_addr[0]) || (ip == allowed_addr[1]) ||
            (ip == allowed_addr[2]) || (ip == allowed_addr[3]);
    if (proto == psf_pkg::PROTO_UDP) len_ok = (len >= psf_pkg::MIN_LEN_UDP);
    else if (proto == psf_pkg::PROTO_TCP) len_ok = (len >= psf_pkg::MIN_LEN_TCP);
    else len_ok = 1'b0;
    return ip_ok && len_ok &&
           (port == psf_pkg::PORT_HTTPS || port == psf_pkg::PORT_ALT ||
            port == psf_pkg::PORT_ALT_HTTPS);
  endfunction

  task automatic predict_stats(logic [31:0] ip, logic [7:0] proto, logic [15:0] len,
                               logic [15:0] port, logic [31:0] lat);
    stats_word_t w;
    int hit, free_idx;
    logic [63:0] acc;
    w = '0;
    hit = -1;
    free_idx = -1;
    if (!passes_filter(ip, proto, len, port)) begin
      n_reject = n_reject + 1;
    end else begin
      w.market = 1'b1;
      n_market = n_market + 1;
      if (min_seen == 0 || lat < min_seen) min_seen = lat;
      if (lat > max_seen) max_seen = lat;
      if (n_market != 0) begin
        acc = 64'(mean_seen) * 64'(n_market - 1) + 64'(lat);
        mean_seen = 32'(acc / 64'(n_market));
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (entry_valid[i]) begin
          if (hit < 0 && entry_addr[i] == ip && entry_port[i] == port) hit = i;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (hit >= 0) begin
        entry_count[hit] = entry_count[hit] + 1;
        entry_sum[hit] = entry_sum[hit] + 48'(lat);
        w.slot = 4'(hit);
        w.packets = entry_count[hit];
        w.lat_total = entry_sum[hit];
      end else if (free_idx >= 0) begin
        entry_valid[free_idx] = 1'b1;
        entry_addr[free_idx] = ip;
        entry_port[free_idx] = port;
        entry_count[free_idx] = 1;
        entry_sum[free_idx] = 48'(lat);
        n_flows = n_flows + 5'd1;
        w.slot = 4'(free_idx);
        w.fresh = 1'b1;
        w.packets = 1;
        w.lat_total = 48'(lat);
      end else begin
        w.full = 1'b1;
      end
    end
    w.market_cnt = n_market;
    w.reject_cnt = n_reject;
    w.lat_min = min_seen;
    w.lat_max = max_seen;
    w.lat_avg = mean_seen;
    w.flows = n_flows;
    expected_words.push_back(w);
  endtask

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    stats_word_t w;
    if (rst) begin
      allowed_addr[0] <= psf_pkg::ALLOWED_IP_0_RESET;
      allowed_addr[1] <= psf_pkg::ALLOWED_IP_1_RESET;
      allowed_addr[2] <= psf_pkg::ALLOWED_IP_2_RESET;
      allowed_addr[3] <= psf_pkg::ALLOWED_IP_3_RESET;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        entry_valid[i] = 1'b0;
        entry_addr[i] = '0;
        entry_port[i] = '0;
        entry_count[i] = '0;
        entry_sum[i] = '0;
      end
      n_market = '0;
      n_reject = '0;
      min_seen = '0;
      max_seen = '0;
      mean_seen = '0;
      n_flows = '0;
      expected_words.delete();
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected", $time);
          fail_count++;
        end else begin
          w = expected_words.pop_front();
          compare_field("is_market", 64'(w.market), 64'(is_market));
          compare_field("flow_slot", 64'(w.slot), 64'(flow_slot));
          compare_field("flow_new", 64'(w.fresh), 64'(flow_new));
          compare_field("table_full", 64'(w.full), 64'(table_full));
          compare_field("flow_packets", 64'(w.packets), 64'(flow_packets));
          compare_field("flow_latency_total", 64'(w.lat_total), 64'(flow_latency_total));
          compare_field("market_total", 64'(w.market_cnt), 64'(market_total));
          compare_field("filtered_total", 64'(w.reject_cnt), 64'(filtered_total));
          compare_field("latency_min", 64'(w.lat_min), 64'(latency_min));
          compare_field("latency_max", 64'(w.lat_max), 64'(latency_max));
          compare_field("latency_avg", 64'(w.lat_avg), 64'(latency_avg));
          compare_field("active_flows", 64'(w.flows), 64'(active_flows));
          if (w.market) matched_seen++;
          if (w.full) full_seen++;
        end
      end
      if (start && !busy) predict_stats(src_ip, protocol, packet_length, src_port, latency);
      if (wr_en) allowed_addr[wr_index] <= wr_data;
    end
    pending = expected_words.size();
  end
endmodule

// ----- bench/tb_packet_source_filter_flow_stats.sv -----
// Testbench top for packet_source_filter_flow_stats: clock, reset, packet and register
// stimulus with random gaps, watchdog and verdict. Depends on psf_pkg, the block and
// psf_flow_stats_checker, which does all prediction and comparison.
module tb_packet_source_filter_flow_stats;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;

  logic clk, rst, start, busy, wr_en, done;
  logic [31:0] src_ip, latency, wr_data;
  logic [7:0] protocol;
  logic [15:0] packet_length, src_port;
  logic [psf_pkg::REG_IDX_W-1:0] wr_index;
  logic is_market, flow_new, table_full;
  logic [3:0] flow_slot;
  logic [31:0] flow_packets, market_total, filtered_total;
  logic [31:0] latency_min, latency_max, latency_avg;
  logic [47:0] flow_latency_total;
  logic [4:0] active_flows;
  int fail_count, pending, matched_seen, full_seen;

  logic [31:0] addr_set[4];
  logic [15:0] good_ports[3] =
    '{psf_pkg::PORT_HTTPS, psf_pkg::PORT_ALT, psf_pkg::PORT_ALT_HTTPS};
  logic [psf_pkg::REG_IDX_W-1:0] reg_ids[4] =
    '{psf_pkg::REG_ALLOWED_IP_0, psf_pkg::REG_ALLOWED_IP_1, psf_pkg::REG_ALLOWED_IP_2,
      psf_pkg::REG_ALLOWED_IP_3};
  int words_sent, settings_used, quiet_cycles;
  logic no_gaps;

  packet_source_filter_flow_stats dut (.*);

  psf_flow_stats_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || wr_en) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] ip, logic [7:0] proto, logic [15:0] len,
                           logic [15:0] port, logic [31:0] lat, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_ip <= ip;
    protocol <= proto;
    packet_length <= len;
    src_port <= port;
    latency <= lat;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic set_addresses(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                               logic [31:0] a3);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    addr_set = '{a0, a1, a2, a3};
    for (int i = 0; i < 4; i++) begin
      wr_en <= 1'b1;
      wr_index <= reg_ids[i];
      wr_data <= addr_set[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_latency();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'd0;
    if (r < 12) return $urandom_range(1, 5000);
    return $urandom;
  endfunction

  task automatic send_random(int count);
    logic [31:0] ip;
    logic [7:0] proto;
    logic [15:0] len, port;
    int r;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      ip = addr_set[$urandom_range(0, 3)];
      proto = $urandom_range(0, 1) ? psf_pkg::PROTO_UDP : psf_pkg::PROTO_TCP;
      len = (proto == psf_pkg::PROTO_UDP) ? 16'($urandom_range(28, 65535)) :
                                            16'($urandom_range(40, 65535));
      port = good_ports[$urandom_range(0, 2)];
      r = $urandom_range(0, 99);
      if (r >= 75) begin
        case ($urandom_range(0, 4))
          0: ip = $urandom;
          1: proto = 8'($urandom);
          2: len = (proto == psf_pkg::PROTO_UDP) ? 16'($urandom_range(0, 27)) :
                                                   16'($urandom_range(0, 39));
          3: port = 16'($urandom);
          default: begin
            ip = $urandom;
            proto = 8'($urandom);
            len = 16'($urandom);
            port = 16'($urandom);
          end
        endcase
      end
      send_word(ip, proto, len, port, pick_latency(), pick_gap());
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    wr_en = 1'b0;
    wr_index = psf_pkg::REG_ALLOWED_IP_0;
    wr_data = '0;
    src_ip = '0;
    protocol = '0;
    packet_length = '0;
    src_port = '0;
    latency = '0;
    no_gaps = 1'b0;
    words_sent = 0;
    settings_used = 0;
    addr_set = '{psf_pkg::ALLOWED_IP_0_RESET, psf_pkg::ALLOWED_IP_1_RESET,
                 psf_pkg::ALLOWED_IP_2_RESET, psf_pkg::ALLOWED_IP_3_RESET};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed packets under the reset addresses: length and port boundaries,
    // other protocols, a zero latency that returns the minimum to its unset value of zero, and flow hits.
    send_word(psf_pkg::ALLOWED_IP_0_RESET, psf_pkg::PROTO_UDP, psf_pkg::MIN_LEN_UDP,
              psf_pkg::PORT_HTTPS, 32'd100, 0);
    send_word(psf_pkg::ALLOWED_IP_1_RESET, psf_pkg::PROTO_TCP, psf_pkg::MIN_LEN_TCP,
              psf_pkg::PORT_ALT, 32'd50, 0);
    send_word(psf_pkg::ALLOWED_IP_0_RESET, psf_pkg::PROTO_UDP, 16'd27,
              psf_pkg::PORT_HTTPS, 32'd7, 1);
    send_word(psf_pkg::ALLOWED_IP_0_RESET, psf_pkg::PROTO_TCP, 16'd39,
              psf_pkg::PORT_HTTPS, 32'd7, 0);
    send_word(psf_pkg::ALLOWED_IP_2_RESET, psf_pkg::PROTO_TCP, psf_pkg::MIN_LEN_UDP,
              psf_pkg::PORT_HTTPS, 32'd7, 0);
    send_word(psf_pkg::ALLOWED_IP_2_RESET, 8'd0, 16'hFFFF, psf_pkg::PORT_HTTPS, 32'd7, 2);
    send_word(psf_pkg::ALLOWED_IP_2_RESET, 8'hFF, 16'hFFFF, psf_pkg::PORT_HTTPS, 32'd7, 0);
    send_word(psf_pkg::ALLOWED_IP_3_RESET, psf_pkg::PROTO_UDP, 16'hFFFF,
              psf_pkg::PORT_ALT_HTTPS, 32'd0, 0);
    send_word(psf_pkg::ALLOWED_IP_3_RESET, psf_pkg::PROTO_UDP, 16'hFFFF,
              psf_pkg::PORT_ALT_HTTPS, 32'd5, 0);
    send_word(psf_pkg::ALLOWED_IP_3_RESET, psf_pkg::PROTO_TCP, 16'd1500, 16'hFFFF, 32'd5, 0);
    send_word(psf_pkg::ALLOWED_IP_3_RESET, psf_pkg::PROTO_TCP, 16'd1500, 16'd0, 32'd5, 3);
    send_word(32'hFFFF_FFFF, psf_pkg::PROTO_UDP, 16'd100, psf_pkg::PORT_HTTPS, 32'd5, 0);
    send_word(32'h0000_0000, psf_pkg::PROTO_UDP, 16'd100, psf_pkg::PORT_HTTPS, 32'd5, 0);
    send_word(psf_pkg::ALLOWED_IP_0_RESET, psf_pkg::PROTO_UDP, 16'd64,
              psf_pkg::PORT_HTTPS, 32'hFFFF_FFFF, 0);
    send_word(psf_pkg::ALLOWED_IP_0_RESET, psf_pkg::PROTO_TCP, 16'd64,
              psf_pkg::PORT_HTTPS, 32'hFFFF_FFFF, 0);
    send_word(psf_pkg::ALLOWED_IP_1_RESET, psf_pkg::PROTO_TCP, 16'd41,
              psf_pkg::PORT_ALT, 32'd1, 0);
    send_word(psf_pkg::ALLOWED_IP_2_RESET, psf_pkg::PROTO_UDP, 16'd29,
              psf_pkg::PORT_ALT_HTTPS, 32'd3, 0);

    send_random(250);
    set_addresses($urandom, $urandom, $urandom, $urandom);
    send_random(250);
    set_addresses(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_random(250);
    set_addresses($urandom, $urandom, $urandom, $urandom);
    send_random(300);
    set_addresses(psf_pkg::ALLOWED_IP_0_RESET, psf_pkg::ALLOWED_IP_1_RESET,
                  psf_pkg::ALLOWED_IP_2_RESET, psf_pkg::ALLOWED_IP_3_RESET);
    send_random(300);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d packets under %0d address settings.", words_sent, settings_used + 1);
    $display("%0d were matched and %0d found the flow table full.", matched_seen, full_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/psf_pkg.sv
design/psf_div.sv
design/psf_flow_mem.sv
design/packet_source_filter_flow_stats.sv
bench/psf_flow_stats_checker.sv
bench/tb_packet_source_filter_flow_stats.sv
